// ----- src/ir_occlusion_position_tracker_core_defines.svh -----
// assertion macros for the ir occlusion position tracker
// no dependencies; expects aclk and aresetn in the including scope
`ifndef IR_OCCLUSION_POSITION_TRACKER_CORE_DEFINES_SVH
`define IR_OCCLUSION_POSITION_TRACKER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define IOPT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
`define IOPT_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);
`else
`define IOPT_ASSERT(lbl, prop, msg)
`define IOPT_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ----- src/iopt_pkg.sv -----
// shared types and constants for the ir occlusion position tracker
// no dependencies
package iopt_pkg;

    localparam int CHANNELS             = 6;
    localparam int SAMPLE_W             = 12;
    localparam int SUM_W                = 20;
    localparam int CMD_W                = 8;
    localparam int POS_W                = 3;
    localparam int DEFAULT_SAMPLE_COUNT = 16;

    localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 12'd200;

    localparam logic [CMD_W-1:0] CMD_RECAL = 8'h43;
    localparam logic [CMD_W-1:0] CMD_QUERY = 8'h47;

    typedef enum logic [1:0] {
        KIND_REPORT = 2'd0,
        KIND_QUERY  = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [POS_W-1:0]   position;
        logic [CMD_W-1:0]   bad_command;
    } result_t;

    typedef struct packed {
        logic clear;
        logic accum;
        logic finish;
        logic track;
    } chan_ctrl_t;

endpackage

// ----- src/iopt_channel.sv -----
// one sensor channel: calibration sum, ambient level, running average, cover test
// depends on iopt_pkg
module iopt_channel
    import iopt_pkg::*;
#(
    parameter int SAMPLE_COUNT = DEFAULT_SAMPLE_COUNT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  chan_ctrl_t          ctrl,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic [SAMPLE_W-1:0] threshold,
    output logic                covered
);

    localparam int L      = $clog2(SAMPLE_COUNT);
    localparam int CAL_K  = SUM_W + L;
    localparam int CAL_MW = SUM_W + 2;
    localparam int CAL_PW = CAL_K + SAMPLE_W;
    localparam int T_W    = SAMPLE_W + 1;
    localparam int AVG_K  = T_W + L;
    localparam int AVG_MW = T_W + 2;
    localparam int AVG_PW = AVG_K + SAMPLE_W;

    localparam logic [CAL_MW-1:0] CAL_M =
        CAL_MW'(((64'd1 << CAL_K) + SAMPLE_COUNT - 1) / SAMPLE_COUNT);
    localparam logic [AVG_MW-1:0] AVG_M =
        AVG_MW'(((64'd1 << AVG_K) + SAMPLE_COUNT - 1) / SAMPLE_COUNT);
    localparam logic [T_W-1:0] ROUND_UP = T_W'(SAMPLE_COUNT - 1);

    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [SAMPLE_W-1:0] avg_reg, avg_next;
    logic [SAMPLE_W-1:0] amb_reg, amb_next;

    logic [SUM_W-1:0]    sum_acc;
    logic [CAL_PW-1:0]   cal_prod;
    logic [SAMPLE_W-1:0] mean;
    logic [T_W-1:0]      diff;
    logic                neg;
    logic [T_W-1:0]      mag;
    logic [T_W-1:0]      t_val;
    logic [AVG_PW-1:0]   avg_prod;
    logic [SAMPLE_W-1:0] step;
    logic [SAMPLE_W-1:0] avg_upd;
    logic [T_W-1:0]      drop;

    // truncated mean of the finished sum, by reciprocal
    assign sum_acc  = sum_reg + SUM_W'(sample);
    assign cal_prod = CAL_PW'(sum_acc) * CAL_PW'(CAL_M);
    assign mean     = cal_prod[CAL_K +: SAMPLE_W];

    // avg + floor((sample - avg) / n)
    assign diff     = {1'b0, sample} - {1'b0, avg_reg};
    assign neg      = diff[T_W-1];
    assign mag      = neg ? (~diff + T_W'(1)) : diff;
    assign t_val    = neg ? (mag + ROUND_UP) : mag;
    assign avg_prod = AVG_PW'(t_val) * AVG_PW'(AVG_M);
    assign step     = avg_prod[AVG_K +: SAMPLE_W];
    assign avg_upd  = neg ? (avg_reg - step) : (avg_reg + step);

    assign drop    = {1'b0, amb_reg} - {1'b0, avg_upd};
    assign covered = $signed(drop) >= $signed({1'b0, threshold});

    always_comb begin
        sum_next = sum_reg;
        avg_next = avg_reg;
        amb_next = amb_reg;
        if (ctrl.clear) begin
            sum_next = '0;
        end else if (ctrl.accum) begin
            sum_next = sum_acc;
            if (ctrl.finish) begin
                avg_next = mean;
                amb_next = mean;
            end
        end else if (ctrl.track) begin
            avg_next = avg_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
            avg_reg <= '0;
            amb_reg <= '0;
        end else begin
            sum_reg <= sum_next;
            avg_reg <= avg_next;
            amb_reg <= amb_next;
        end
    end

endmodule

// ----- src/iopt_out_reg.sv -----
// result register holding one finished result until the receiver takes it
// depends on iopt_pkg
module iopt_out_reg
    import iopt_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  result_t res_in,
    input  logic    taken,
    output logic    valid,
    output result_t res_out
);

    logic    valid_reg, valid_next;
    result_t res_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (taken) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_in;
        end
    end

    assign valid   = valid_reg;
    assign res_out = res_reg;

endmodule

// ----- src/ir_occlusion_position_tracker_core.sv -----
// ir occlusion position tracker: top level
// depends on iopt_pkg, iopt_channel, iopt_out_reg and the defines header
//
// s_ channel carries one item per transfer: a set of six 12-bit readings
// (s_tuser = 0) or a command byte (s_tuser = 1). m_ channel carries results:
// position change reports, query replies and unknown command errors.
// cfg_ channel writes the 12-bit cover threshold; write only while idle.
// An item transferred on s_ lands in an input register and is processed
// once the output register is free; its result, if any, is loaded into
// that register and shows on m_. One item per cycle is sustained while no
// result waits; average update and reciprocal divide are combinational.
// The first SAMPLE_COUNT sample sets after reset or a recalibrate command
// only build the ambient levels and give no result.
// Reset clears the result register, the input register and the tracking
// state, loads the threshold with 200 and starts a calibration.
// When m_tready is low the result waits in the output register; one more
// item is still taken into the input register, then s_tready drops.
`include "ir_occlusion_position_tracker_core_defines.svh"

module ir_occlusion_position_tracker_core
    import iopt_pkg::*;
#(
    parameter int SAMPLE_COUNT = DEFAULT_SAMPLE_COUNT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [79:0]         s_tdata,   // command_byte, sample_0 .. sample_5
    input  logic [0:0]          s_tuser,   // mode
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,   // position, bad_command, zero fill
    output logic [1:0]          m_tuser,   // kind
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [SAMPLE_W-1:0] cfg_data
);

    localparam int CNT_W = $clog2(SAMPLE_COUNT + 1);
    localparam logic [CNT_W-1:0] COUNT_END = CNT_W'(SAMPLE_COUNT);

    logic                               in_valid_reg, in_valid_next;
    logic                               in_mode_reg;
    logic [CMD_W-1:0]                   in_cmd_reg;
    logic [CHANNELS-1:0][SAMPLE_W-1:0]  in_samples_reg;

    logic [SAMPLE_W-1:0] threshold_reg, threshold_next;
    logic                calibrating_reg, calibrating_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [POS_W-1:0]    last_pos_reg, last_pos_next;

    logic                s_accept;
    logic                proc_fire;
    logic                out_valid;
    result_t             out_res;
    result_t             res;
    logic                res_load;
    chan_ctrl_t          ctrl;
    logic [CHANNELS-1:0] covered;
    logic [POS_W-1:0]    pos;
    logic [CNT_W-1:0]    count_plus;
    logic                is_recal;
    logic                is_query;

    assign s_accept  = s_tvalid && s_tready;
    assign proc_fire = in_valid_reg && (!out_valid || m_tready);
    assign s_tready  = !in_valid_reg || proc_fire;
    assign cfg_ready = 1'b1;

    // input register
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (proc_fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_mode_reg    <= s_tuser[0];
            in_cmd_reg     <= s_tdata[7:0];
            in_samples_reg <= s_tdata[79:8];
        end
    end

    // item decode
    assign is_recal   = in_mode_reg && (in_cmd_reg == CMD_RECAL);
    assign is_query   = in_mode_reg && (in_cmd_reg == CMD_QUERY);
    assign count_plus = count_reg + CNT_W'(1);

    always_comb begin
        ctrl.clear  = proc_fire && is_recal;
        ctrl.accum  = proc_fire && !in_mode_reg && calibrating_reg;
        ctrl.finish = ctrl.accum && (count_plus >= COUNT_END);
        ctrl.track  = proc_fire && !in_mode_reg && !calibrating_reg;
    end

    for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
        iopt_channel #(
            .SAMPLE_COUNT(SAMPLE_COUNT)
        ) u_chan (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl),
            .sample   (in_samples_reg[c]),
            .threshold(threshold_reg),
            .covered  (covered[c])
        );
    end

    // deepest covered sensor wins
    always_comb begin
        pos = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            if (covered[c]) begin
                pos = POS_W'(c + 1);
            end
        end
    end

    always_comb begin
        res      = '{kind: KIND_REPORT, position: pos, bad_command: '0};
        res_load = 1'b0;
        if (in_mode_reg) begin
            if (is_query) begin
                res      = '{kind: KIND_QUERY, position: last_pos_reg, bad_command: '0};
                res_load = proc_fire;
            end else if (!is_recal) begin
                res      = '{kind: KIND_ERROR, position: '0, bad_command: in_cmd_reg};
                res_load = proc_fire;
            end
        end else begin
            res_load = ctrl.track && (pos != last_pos_reg);
        end
    end

    // tracking state
    always_comb begin
        threshold_next   = threshold_reg;
        calibrating_next = calibrating_reg;
        count_next       = count_reg;
        last_pos_next    = last_pos_reg;
        if (cfg_valid && cfg_ready) begin
            threshold_next = cfg_data;
        end
        if (ctrl.clear) begin
            calibrating_next = 1'b1;
            count_next       = '0;
        end else if (ctrl.accum) begin
            count_next = count_plus;
            if (ctrl.finish) begin
                calibrating_next = 1'b0;
            end
        end
        if (ctrl.track && (pos != last_pos_reg)) begin
            last_pos_next = pos;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg   <= THRESHOLD_RESET;
            calibrating_reg <= 1'b1;
            count_reg       <= '0;
            last_pos_reg    <= '0;
        end else begin
            threshold_reg   <= threshold_next;
            calibrating_reg <= calibrating_next;
            count_reg       <= count_next;
            last_pos_reg    <= last_pos_next;
        end
    end

    iopt_out_reg u_out (
        .aclk   (aclk),
        .aresetn(aresetn),
        .load   (res_load),
        .res_in (res),
        .taken  (m_tready),
        .valid  (out_valid),
        .res_out(out_res)
    );

    assign m_tvalid = out_valid;
    assign m_tuser  = out_res.kind;
    assign m_tdata  = {5'b0, out_res.bad_command, out_res.position};

    `IOPT_ASSERT(a_count_range, calibrating_reg |-> (count_reg < COUNT_END), "calibration count past end")
    `IOPT_ASSERT(a_report_change, (res_load && !in_mode_reg) |=> (last_pos_reg != $past(last_pos_reg)), "report without position change")
    `IOPT_ASSERT(a_load_free, res_load |-> (!out_valid || m_tready), "result register overwritten")
    `IOPT_ASSERT_RST(a_reset_state, !aresetn |=> (calibrating_reg && threshold_reg == THRESHOLD_RESET), "bad state after reset")

endmodule

// ----- bench/tb_top.sv -----
// testbench for ir_occlusion_position_tracker_core: directed and random stream traffic
// checked against a tracker predictor; depends on iopt_pkg and the core rtl
`timescale 1ns / 1ps

module tb_top
    import iopt_pkg::*;
();

    localparam int SETS_PER_CAL   = DEFAULT_SAMPLE_COUNT;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;

    typedef struct packed {
        logic        mode;
        logic [79:0] data;
    } feed_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [79:0]         s_tdata   = '0;   // command_byte, sample_0 .. sample_5
    logic [0:0]          s_tuser   = '0;   // mode
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [15:0]         m_tdata;          // position, bad_command, zero fill
    logic [1:0]          m_tuser;          // kind
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [SAMPLE_W-1:0] cfg_data  = '0;

    ir_occlusion_position_tracker_core #(
        .SAMPLE_COUNT(SETS_PER_CAL)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    // tracker state mirrored by the predictor
    logic [SAMPLE_W-1:0] avg_lvl [CHANNELS];
    logic [SAMPLE_W-1:0] amb_lvl [CHANNELS];
    logic [SUM_W-1:0]    cal_sum [CHANNELS];
    logic [8:0]          cal_cnt;
    logic                cal_active;
    logic [POS_W-1:0]    cur_pos;
    logic [SAMPLE_W-1:0] cover_thr;

    feed_t   sensor_items[$];
    result_t expected_reports[$];
    result_t want;

    logic s_took   = 1'b0;
    logic cfg_took = 1'b0;
    logic m_took;
    int   idle_cycles = 0;
    int   err_count   = 0;
    int   items_in    = 0;
    int   results_out = 0;
    int   cfg_writes  = 0;
    int   burst_left  = 0;
    int   gap_left    = 0;
    int   style_left  = 0;
    int   stall_style = 0;
    logic rdy;
    feed_t next_item;

    task automatic advance_tracker(input logic mode, input logic [79:0] data);
        logic [CMD_W-1:0]    cmd;
        logic [SAMPLE_W-1:0] smp;
        logic [POS_W-1:0]    pos;
        result_t             r;
        cmd = data[7:0];
        r   = '0;
        if (mode) begin
            if (cmd == CMD_RECAL) begin
                for (int c = 0; c < CHANNELS; c++) cal_sum[c] = '0;
                cal_cnt    = '0;
                cal_active = 1'b1;
            end else if (cmd == CMD_QUERY) begin
                r.kind     = KIND_QUERY;
                r.position = cur_pos;
                expected_reports.push_back(r);
            end else begin
                r.kind        = KIND_ERROR;
                r.bad_command = cmd;
                expected_reports.push_back(r);
            end
        end else if (cal_active) begin
            for (int c = 0; c < CHANNELS; c++) begin
                smp        = data[8 + SAMPLE_W*c +: SAMPLE_W];
                cal_sum[c] = cal_sum[c] + {8'd0, smp};
            end
            cal_cnt = cal_cnt + 9'd1;
            if (cal_cnt >= SETS_PER_CAL) begin
                for (int c = 0; c < CHANNELS; c++) begin
                    avg_lvl[c] = SAMPLE_W'(cal_sum[c] / SETS_PER_CAL);
                    amb_lvl[c] = avg_lvl[c];
                end
                cal_active = 1'b0;
            end
        end else begin
            for (int c = 0; c < CHANNELS; c++) begin
                smp        = data[8 + SAMPLE_W*c +: SAMPLE_W];
                avg_lvl[c] = SAMPLE_W'((int'(avg_lvl[c]) * (SETS_PER_CAL - 1) + int'(smp))
                                       / SETS_PER_CAL);
            end
            pos = '0;
            for (int c = CHANNELS - 1; c >= 0; c--) begin
                if (pos == 0 && int'(amb_lvl[c]) - int'(avg_lvl[c]) >= int'(cover_thr))
                    pos = POS_W'(c + 1);
            end
            if (pos != cur_pos) begin
                cur_pos    = pos;
                r.kind     = KIND_REPORT;
                r.position = pos;
                expected_reports.push_back(r);
            end
        end
    endtask

    function automatic void check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            err_count++;
        end
    endfunction

    // monitor, predictor feed and watchdog
    always @(posedge aclk) begin
        s_took   = s_tvalid && s_tready;
        cfg_took = cfg_valid && cfg_ready;
        m_took   = m_tvalid && m_tready;
        if (!aresetn) begin
            for (int c = 0; c < CHANNELS; c++) begin
                avg_lvl[c] = '0;
                amb_lvl[c] = '0;
                cal_sum[c] = '0;
            end
            cal_cnt    = '0;
            cal_active = 1'b1;
            cur_pos    = '0;
            cover_thr  = THRESHOLD_RESET;
        end else begin
            if (s_took) begin
                items_in++;
                advance_tracker(s_tuser[0], s_tdata);
            end
            if (cfg_took) begin
                cover_thr = cfg_data;
                cfg_writes++;
            end
            if (m_took) begin
                if (expected_reports.size() == 0) begin
                    $error("unexpected result transfer: kind %0d, position %0d, bad_command %0d",
                           m_tuser, m_tdata[2:0], m_tdata[10:3]);
                    err_count++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("kind", int'(want.kind), int'(m_tuser));
                    check_field("position", int'(want.position), int'(m_tdata[2:0]));
                    check_field("bad_command", int'(want.bad_command), int'(m_tdata[10:3]));
                    results_out++;
                end
            end
        end
        if (s_took || cfg_took || m_took) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     idle_cycles, expected_reports.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // sender: bursts of random length separated by random gaps
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_took) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (sensor_items.size() > 0) begin
                next_item = sensor_items.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= next_item.mode;
                s_tdata  <= next_item.data;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 7);
                end else begin
                    burst_left--;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern switches between a few styles
    always @(negedge aclk) begin
        if (style_left == 0) begin
            stall_style = $urandom_range(0, 3);
            style_left  = $urandom_range(16, 96);
        end
        style_left--;
        case (stall_style)
            0: rdy = 1'b1;
            1: rdy = ($urandom_range(0, 9) < 7);
            2: rdy = ((style_left % 16) >= 10);
            default: rdy = ((style_left % 3) != 0);
        endcase
        m_tready <= rdy;
    end

    task automatic push_set(input logic [71:0] readings);
        feed_t f;
        f.mode = 1'b0;
        f.data = {readings, 8'($urandom)};
        sensor_items.push_back(f);
    endtask

    task automatic push_cmd(input logic [CMD_W-1:0] cmd);
        feed_t       f;
        logic [95:0] r96;
        r96    = {$urandom, $urandom, $urandom};
        f.mode = 1'b1;
        f.data = {r96[71:0], cmd};
        sensor_items.push_back(f);
    endtask

    // sampled at the rising edge, where queue and s_tvalid are settled
    task automatic wait_drained();
        do @(posedge aclk);
        while (sensor_items.size() != 0 || s_tvalid || expected_reports.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_threshold(input logic [SAMPLE_W-1:0] v);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(negedge aclk);
        while (!cfg_took);
        cfg_valid <= 1'b0;
    endtask

    // probe moves along the sensors; covered channels read base minus a drop
    task automatic fill_phase(input int n_items, input int base_lo, input int base_hi,
                              input int drop_lo, input int drop_hi, input int hold);
        int          base [CHANNELS];
        int          depth;
        int          roll;
        int          v;
        logic [71:0] rd;
        logic [95:0] r96;
        for (int c = 0; c < CHANNELS; c++) base[c] = $urandom_range(base_lo, base_hi);
        depth = 0;
        push_cmd(CMD_RECAL);
        for (int k = 0; k < n_items; k++) begin
            if (k >= SETS_PER_CAL && $urandom_range(1, hold) == 1)
                depth = $urandom_range(0, CHANNELS);
            roll = $urandom_range(0, 99);
            if (roll < 4) begin
                push_cmd(CMD_QUERY);
            end else if (roll < 7) begin
                push_cmd(8'($urandom));
            end else if (roll == 7) begin
                push_cmd(CMD_RECAL);
            end else if (roll < 12) begin
                r96 = {$urandom, $urandom, $urandom};
                push_set(r96[71:0]);
            end else begin
                for (int c = 0; c < CHANNELS; c++) begin
                    if (c < depth) v = base[c] - $urandom_range(drop_lo, drop_hi);
                    else v = base[c] + $urandom_range(0, 16) - 8;
                    if (v < 0) v = 0;
                    if (v > 4095) v = 4095;
                    rd[SAMPLE_W*c +: SAMPLE_W] = SAMPLE_W'(v);
                end
                push_set(rd);
            end
        end
    endtask

    initial begin
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: commands during calibration, restart, full scale readings
        push_cmd(CMD_QUERY);
        push_cmd(8'h00);
        push_cmd(8'hFF);
        push_set({6{12'h000}});
        push_set({6{12'h000}});
        push_cmd(CMD_RECAL);
        for (int k = 0; k < SETS_PER_CAL; k++) push_set({6{12'hFFF}});
        push_cmd(CMD_QUERY);
        push_set({{5{12'hFFF}}, 12'h000});
        push_set({6{12'h000}});
        push_cmd(CMD_QUERY);
        push_cmd(8'h30);
        push_cmd(8'h36);
        for (int k = 0; k < 6; k++) push_set({6{12'hFFF}});
        push_cmd(CMD_QUERY);
        wait_drained();

        fill_phase(170, 300, 3800, 150, 600, 12);
        wait_drained();

        // zero threshold: an unchanged average already counts as covered
        write_threshold(12'd0);
        fill_phase(160, 0, 4095, 0, 300, 10);
        wait_drained();

        // full scale threshold needs ambient at 4095 and the average decayed to 0
        write_threshold(12'hFFF);
        push_cmd(CMD_RECAL);
        for (int k = 0; k < SETS_PER_CAL; k++) push_set({6{12'hFFF}});
        for (int k = 0; k < 120; k++) push_set({6{12'h000}});
        push_cmd(CMD_QUERY);
        for (int k = 0; k < 8; k++) push_set({6{12'hFFF}});
        wait_drained();

        write_threshold(12'($urandom_range(1, 4094)));
        fill_phase(170, 0, 4095, 0, 4095, 8);
        wait_drained();

        write_threshold(12'd50);
        fill_phase(170, 500, 3500, 40, 200, 6);
        wait_drained();

        write_threshold(12'd1000);
        fill_phase(170, 1500, 4095, 800, 1500, 10);
        wait_drained();

        $display("run covered %0d input transfers, %0d result transfers, %0d threshold writes",
                 items_in, results_out, cfg_writes);
        $display("phases: calibration restarts, queries, bad commands, thresholds 0 to 4095");
        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
